[hdl/rspa_pkg.sv]
// ----------------------------------------------------------------------------
// rspa_pkg
// Shared types, widths and codes for the reserved slot pool admission block.
// ----------------------------------------------------------------------------
package rspa_pkg;

	// Defaults for the top-level parameters
	localparam int SLOTS_DEF     = 8;
	localparam int LISTENERS_DEF = 4;

	// Fixed field widths
	localparam int MAX_LISTENERS = 4;
	localparam int OWNER_W       = 2;
	localparam int RES_W         = 4;
	localparam int LCNT_W        = 3;
	localparam int ENA_W         = 4;
	localparam int CMD_W         = 2;
	localparam int IDX_W         = 3;
	localparam int STATUS_W      = 3;
	localparam int GRANT_W       = 3;
	localparam int COUNT_W       = 4;
	localparam int SHORT_W       = 6;
	localparam int CMP_W         = 8;

	// Configuration port
	localparam int APB_ADDR_W = 5;
	localparam int APB_DATA_W = 32;
	localparam int REG_IDX_W  = 3;

	localparam logic [REG_IDX_W-1:0] REG_RESERVE0 = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_RESERVE1 = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_RESERVE2 = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_RESERVE3 = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_LCOUNT   = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_ENABLE   = 3'd5;

	// Commands
	localparam logic [CMD_W-1:0] CMD_ACCEPT  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd1;
	localparam logic [CMD_W-1:0] CMD_CLOSE   = 2'd2;

	// Result status codes
	localparam logic [STATUS_W-1:0] STATUS_ACCEPTED    = 3'd0;
	localparam logic [STATUS_W-1:0] STATUS_NOT_STARTED = 3'd1;
	localparam logic [STATUS_W-1:0] STATUS_REFUSED     = 3'd2;
	localparam logic [STATUS_W-1:0] STATUS_NO_FREE     = 3'd3;
	localparam logic [STATUS_W-1:0] STATUS_RELEASED    = 3'd4;
	localparam logic [STATUS_W-1:0] STATUS_IGNORED     = 3'd5;
	localparam logic [STATUS_W-1:0] STATUS_ALL_CLOSED  = 3'd6;

	typedef struct packed {
		logic [MAX_LISTENERS-1:0][RES_W-1:0] reserve;
		logic [LCNT_W-1:0]                   listener_count;
		logic [ENA_W-1:0]                    listener_enable;
	} cfg_t;

endpackage

[hdl/rspa_ram.sv]
// ----------------------------------------------------------------------------
// rspa_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module rspa_ram #(
	parameter int WIDTH = 2,
	parameter int DEPTH = 8,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[hdl/rspa_cfg.sv]
// ----------------------------------------------------------------------------
// rspa_cfg
// APB-style register file holding reservations, listener count and enables.
// ----------------------------------------------------------------------------
module rspa_cfg (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [rspa_pkg::APB_ADDR_W-1:0]      paddr,
	input  logic [rspa_pkg::APB_DATA_W-1:0]      pwdata,
	output logic [rspa_pkg::APB_DATA_W-1:0]      prdata,
	output logic                                 pready,
	output rspa_pkg::cfg_t                       cfg
);

	rspa_pkg::cfg_t                 cfg_q;
	logic [rspa_pkg::REG_IDX_W-1:0] reg_idx;
	logic                           wr_en;

	assign reg_idx = paddr[rspa_pkg::APB_ADDR_W-1:2];
	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			case (reg_idx)
				rspa_pkg::REG_RESERVE0: begin
					cfg_q.reserve[0] <= pwdata[rspa_pkg::RES_W-1:0];
				end
				rspa_pkg::REG_RESERVE1: begin
					cfg_q.reserve[1] <= pwdata[rspa_pkg::RES_W-1:0];
				end
				rspa_pkg::REG_RESERVE2: begin
					cfg_q.reserve[2] <= pwdata[rspa_pkg::RES_W-1:0];
				end
				rspa_pkg::REG_RESERVE3: begin
					cfg_q.reserve[3] <= pwdata[rspa_pkg::RES_W-1:0];
				end
				rspa_pkg::REG_LCOUNT: begin
					cfg_q.listener_count <= pwdata[rspa_pkg::LCNT_W-1:0];
				end
				rspa_pkg::REG_ENABLE: begin
					cfg_q.listener_enable <= pwdata[rspa_pkg::ENA_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			rspa_pkg::REG_RESERVE0: prdata = rspa_pkg::APB_DATA_W'(cfg_q.reserve[0]);
			rspa_pkg::REG_RESERVE1: prdata = rspa_pkg::APB_DATA_W'(cfg_q.reserve[1]);
			rspa_pkg::REG_RESERVE2: prdata = rspa_pkg::APB_DATA_W'(cfg_q.reserve[2]);
			rspa_pkg::REG_RESERVE3: prdata = rspa_pkg::APB_DATA_W'(cfg_q.reserve[3]);
			rspa_pkg::REG_LCOUNT:   prdata = rspa_pkg::APB_DATA_W'(cfg_q.listener_count);
			rspa_pkg::REG_ENABLE:   prdata = rspa_pkg::APB_DATA_W'(cfg_q.listener_enable);
			default:                prdata = '0;
		endcase
	end

endmodule

[hdl/rspa_ctrl.sv]
// ----------------------------------------------------------------------------
// rspa_ctrl
// Item sequencer: owner lookup, admission check, slot grant and bookkeeping.
// ----------------------------------------------------------------------------
module rspa_ctrl #(
	parameter int SLOTS     = rspa_pkg::SLOTS_DEF,
	parameter int LISTENERS = rspa_pkg::LISTENERS_DEF,
	localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1,
	localparam int CNT_W  = $clog2(SLOTS + 1)
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  rspa_pkg::cfg_t                    cfg,
	input  logic                              req_valid,
	output logic                              req_ready,
	input  logic [rspa_pkg::CMD_W-1:0]        cmd,
	input  logic [rspa_pkg::OWNER_W-1:0]      listener,
	input  logic [rspa_pkg::IDX_W-1:0]        slot_index,
	output logic                              rsp_valid,
	input  logic                              rsp_ready,
	output logic [rspa_pkg::STATUS_W-1:0]     status,
	output logic [rspa_pkg::GRANT_W-1:0]      granted_slot,
	output logic [rspa_pkg::COUNT_W-1:0]      held_count,
	output logic [rspa_pkg::COUNT_W-1:0]      free_count,
	output logic                              ram_re,
	output logic [SLOT_W-1:0]                 ram_raddr,
	input  logic [rspa_pkg::OWNER_W-1:0]      ram_rdata,
	output logic                              ram_we,
	output logic [SLOT_W-1:0]                 ram_waddr,
	output logic [rspa_pkg::OWNER_W-1:0]      ram_wdata
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_EVAL = 2'd1;
	localparam logic [1:0] ST_EXEC = 2'd2;

	logic [1:0]                        state_q;
	logic [rspa_pkg::CMD_W-1:0]        cmd_q;
	logic [rspa_pkg::OWNER_W-1:0]      who_q;
	logic [rspa_pkg::IDX_W-1:0]        idx_q;
	logic [rspa_pkg::OWNER_W-1:0]      owner_q;
	logic [rspa_pkg::SHORT_W-1:0]      shortfall_q;
	logic [SLOT_W-1:0]                 grant_q;
	logic                              found_q;

	logic [SLOTS-1:0]                  busy_q;
	logic [SLOTS-1:0]                  busy_d;
	logic [CNT_W-1:0]                  held_q [rspa_pkg::MAX_LISTENERS];
	logic [CNT_W-1:0]                  held_d [rspa_pkg::MAX_LISTENERS];
	logic [CNT_W-1:0]                  free_q;
	logic [CNT_W-1:0]                  free_d;

	logic                              rsp_valid_q;
	logic [rspa_pkg::STATUS_W-1:0]     status_q;
	logic [rspa_pkg::GRANT_W-1:0]      granted_q;
	logic [rspa_pkg::COUNT_W-1:0]      heldc_q;
	logic [rspa_pkg::COUNT_W-1:0]      freec_q;

	logic                              accept;
	logic                              exec_fire;
	logic [rspa_pkg::LCNT_W-1:0]       reg_count;
	logic [rspa_pkg::SHORT_W-1:0]      shortfall;
	logic [SLOT_W-1:0]                 pick;
	logic                              pick_found;
	logic                              who_ok;
	logic                              refuse;
	logic                              in_range;
	logic [SLOT_W-1:0]                 idx_s;
	logic [rspa_pkg::STATUS_W-1:0]     status_d;
	logic [rspa_pkg::GRANT_W-1:0]      granted_d;
	logic                              grant_now;

	assign req_ready = (state_q == ST_IDLE);
	assign accept    = req_valid && req_ready;
	assign exec_fire = (state_q == ST_EXEC) && (!rsp_valid_q || rsp_ready);

	assign ram_re    = accept;
	assign ram_raddr = SLOT_W'(slot_index);
	assign ram_we    = exec_fire && grant_now;
	assign ram_waddr = grant_q;
	assign ram_wdata = who_q;

	assign reg_count = (cfg.listener_count < rspa_pkg::LCNT_W'(LISTENERS)) ?
		cfg.listener_count : rspa_pkg::LCNT_W'(LISTENERS);

	// Shortfall of the other registered listeners and lowest free slot.
	// Neither changes between this step and the commit step.
	always_comb begin
		logic [rspa_pkg::CMP_W-1:0] acc;
		acc = '0;
		for (int l = 0; l < rspa_pkg::MAX_LISTENERS; l++) begin
			if ((rspa_pkg::LCNT_W'(l) < reg_count) && (rspa_pkg::OWNER_W'(l) != who_q) &&
				(rspa_pkg::CMP_W'(cfg.reserve[l]) > rspa_pkg::CMP_W'(held_q[l]))) begin
				acc = acc + rspa_pkg::CMP_W'(cfg.reserve[l]) - rspa_pkg::CMP_W'(held_q[l]);
			end
		end
		shortfall = rspa_pkg::SHORT_W'(acc);
	end

	always_comb begin
		pick       = '0;
		pick_found = 1'b0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (!busy_q[i]) begin
				pick       = SLOT_W'(i);
				pick_found = 1'b1;
			end
		end
	end

	assign who_ok   = (rspa_pkg::LCNT_W'(who_q) < reg_count) && cfg.listener_enable[who_q];
	assign refuse   = (rspa_pkg::CMP_W'(held_q[who_q]) >= rspa_pkg::CMP_W'(cfg.reserve[who_q])) &&
		(rspa_pkg::CMP_W'(free_q) <= rspa_pkg::CMP_W'(shortfall_q));
	assign in_range = rspa_pkg::CMP_W'(idx_q) < rspa_pkg::CMP_W'(SLOTS);
	assign idx_s    = SLOT_W'(idx_q);

	always_comb begin
		busy_d    = busy_q;
		held_d    = held_q;
		free_d    = free_q;
		status_d  = rspa_pkg::STATUS_IGNORED;
		granted_d = '0;
		grant_now = 1'b0;
		case (cmd_q)
			rspa_pkg::CMD_ACCEPT: begin
				if (!who_ok) begin
					status_d = rspa_pkg::STATUS_NOT_STARTED;
				end else if (refuse) begin
					status_d = rspa_pkg::STATUS_REFUSED;
				end else if (!found_q) begin
					status_d = rspa_pkg::STATUS_NO_FREE;
				end else begin
					status_d        = rspa_pkg::STATUS_ACCEPTED;
					grant_now       = 1'b1;
					busy_d[grant_q] = 1'b1;
					held_d[who_q]   = held_q[who_q] + 1'b1;
					free_d          = free_q - 1'b1;
					granted_d       = rspa_pkg::GRANT_W'(grant_q);
				end
			end
			rspa_pkg::CMD_RELEASE: begin
				if (in_range && busy_q[idx_s]) begin
					status_d        = rspa_pkg::STATUS_RELEASED;
					busy_d[idx_s]   = 1'b0;
					held_d[owner_q] = held_q[owner_q] - 1'b1;
					free_d          = free_q + 1'b1;
				end
			end
			rspa_pkg::CMD_CLOSE: begin
				status_d = rspa_pkg::STATUS_ALL_CLOSED;
				busy_d   = '0;
				for (int l = 0; l < rspa_pkg::MAX_LISTENERS; l++) begin
					held_d[l] = '0;
				end
				free_d = CNT_W'(SLOTS);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			busy_q      <= '0;
			free_q      <= CNT_W'(SLOTS);
			rsp_valid_q <= 1'b0;
			for (int l = 0; l < rspa_pkg::MAX_LISTENERS; l++) begin
				held_q[l] <= '0;
			end
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_EVAL;
					end
				end
				ST_EVAL: begin
					state_q <= ST_EXEC;
				end
				ST_EXEC: begin
					if (exec_fire) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (exec_fire) begin
				busy_q      <= busy_d;
				held_q      <= held_d;
				free_q      <= free_d;
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= cmd;
			who_q <= listener;
			idx_q <= slot_index;
		end
		if (state_q == ST_EVAL) begin
			owner_q     <= ram_rdata;
			shortfall_q <= shortfall;
			grant_q     <= pick;
			found_q     <= pick_found;
		end
		if (exec_fire) begin
			status_q  <= status_d;
			granted_q <= granted_d;
			heldc_q   <= rspa_pkg::COUNT_W'(held_d[who_q]);
			freec_q   <= rspa_pkg::COUNT_W'(free_d);
		end
	end

	assign rsp_valid    = rsp_valid_q;
	assign status       = status_q;
	assign granted_slot = granted_q;
	assign held_count   = heldc_q;
	assign free_count   = freec_q;

endmodule

[hdl/reserved_slot_pool_admission.sv]
// ----------------------------------------------------------------------------
// reserved_slot_pool_admission
// Shared connection slot pool with a guaranteed minimum per listener.
// ----------------------------------------------------------------------------
// Requests arrive on the req channel (cmd, listener, slot_index) and each
// produces exactly one result on the rsp channel (status, granted_slot,
// held_count, free_count), both with valid/ready handshakes. An accept
// request is admitted against the listener reservations and gets the lowest
// free slot; a release frees one slot; close-all frees the whole pool.
// An item takes three steps: the owner memory is read in the first, the
// shortfall of other listeners and the lowest free slot are found in the
// second, and the pool is updated and the result registered in the third.
// The controller takes no new item until the third step has committed.
// Reset frees all slots and clears the configuration registers at once;
// no clearing pass is needed. While the receiver stalls the result stays
// in its output register; the next item is taken and evaluated, and holds
// in its final step until the output register is free. The user must
// write configuration through the APB port only while no item is in
// flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module reserved_slot_pool_admission #(
	parameter int SLOTS     = rspa_pkg::SLOTS_DEF,
	parameter int LISTENERS = rspa_pkg::LISTENERS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [rspa_pkg::APB_ADDR_W-1:0]   paddr,
	input  logic [rspa_pkg::APB_DATA_W-1:0]   pwdata,
	output logic [rspa_pkg::APB_DATA_W-1:0]   prdata,
	output logic                              pready,
	input  logic                              req_valid,
	output logic                              req_ready,
	input  logic [rspa_pkg::CMD_W-1:0]        cmd,
	input  logic [rspa_pkg::OWNER_W-1:0]      listener,
	input  logic [rspa_pkg::IDX_W-1:0]        slot_index,
	output logic                              rsp_valid,
	input  logic                              rsp_ready,
	output logic [rspa_pkg::STATUS_W-1:0]     status,
	output logic [rspa_pkg::GRANT_W-1:0]      granted_slot,
	output logic [rspa_pkg::COUNT_W-1:0]      held_count,
	output logic [rspa_pkg::COUNT_W-1:0]      free_count
);

	localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	rspa_pkg::cfg_t                  cfg;
	logic                            ram_re;
	logic [SLOT_W-1:0]               ram_raddr;
	logic [rspa_pkg::OWNER_W-1:0]    ram_rdata;
	logic                            ram_we;
	logic [SLOT_W-1:0]               ram_waddr;
	logic [rspa_pkg::OWNER_W-1:0]    ram_wdata;

	rspa_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Slot owner store: written when a slot is granted, read for each request and used on release.
	rspa_ram #(
		.WIDTH (rspa_pkg::OWNER_W),
		.DEPTH (SLOTS)
	) u_owner_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	rspa_ctrl #(
		.SLOTS     (SLOTS),
		.LISTENERS (LISTENERS)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.req_valid    (req_valid),
		.req_ready    (req_ready),
		.cmd          (cmd),
		.listener     (listener),
		.slot_index   (slot_index),
		.rsp_valid    (rsp_valid),
		.rsp_ready    (rsp_ready),
		.status       (status),
		.granted_slot (granted_slot),
		.held_count   (held_count),
		.free_count   (free_count),
		.ram_re       (ram_re),
		.ram_raddr    (ram_raddr),
		.ram_rdata    (ram_rdata),
		.ram_we       (ram_we),
		.ram_waddr    (ram_waddr),
		.ram_wdata    (ram_wdata)
	);

endmodule

[tb/sv/tb_reserved_slot_pool_admission.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_reserved_slot_pool_admission
// Self-checking testbench for the reserved slot pool admission block.
// ----------------------------------------------------------------------------
// Requests go in on the req channel and each one is run through a local
// model of the pool (slot ownership, reservations, register shadow) at the
// edge where it is accepted. Every result from the rsp channel is compared
// field by field with the oldest outstanding prediction. The run covers a
// few directed sequences for the corner cases, then random traffic under
// several register settings. The sender idles in bursts and the receiver
// stalls in patterns of its own, including one long hold-off.
// ----------------------------------------------------------------------------
module tb_reserved_slot_pool_admission;

	localparam int SLOTS     = rspa_pkg::SLOTS_DEF;
	localparam int LISTENERS = rspa_pkg::LISTENERS_DEF;
	localparam int LONG_HOLD = 200;
	localparam int ITEMS_PER_SETTING = 200;

	// The unused command encoding is answered as an ignored request.
	localparam logic [rspa_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

	localparam logic [1:0] RCV_ALWAYS   = 2'd0;
	localparam logic [1:0] RCV_COIN     = 2'd1;
	localparam logic [1:0] RCV_SPARSE   = 2'd2;
	localparam logic [1:0] RCV_PERIODIC = 2'd3;

	typedef struct packed {
		logic [rspa_pkg::CMD_W-1:0]   op;
		logic [rspa_pkg::OWNER_W-1:0] who;
		logic [rspa_pkg::IDX_W-1:0]   idx;
	} pool_req_t;

	typedef struct packed {
		logic [rspa_pkg::STATUS_W-1:0] status;
		logic [rspa_pkg::GRANT_W-1:0]  granted;
		logic [rspa_pkg::COUNT_W-1:0]  held;
		logic [rspa_pkg::COUNT_W-1:0]  free;
	} pool_outcome_t;

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            psel = 1'b0;
	logic                            penable = 1'b0;
	logic                            pwrite = 1'b0;
	logic [rspa_pkg::APB_ADDR_W-1:0] paddr = '0;
	logic [rspa_pkg::APB_DATA_W-1:0] pwdata = '0;
	logic [rspa_pkg::APB_DATA_W-1:0] prdata;
	logic                            pready;
	logic                            req_valid = 1'b0;
	logic                            req_ready;
	logic [rspa_pkg::CMD_W-1:0]      cmd = '0;
	logic [rspa_pkg::OWNER_W-1:0]    listener = '0;
	logic [rspa_pkg::IDX_W-1:0]      slot_index = '0;
	logic                            rsp_valid;
	logic                            rsp_ready = 1'b0;
	logic [rspa_pkg::STATUS_W-1:0]   status;
	logic [rspa_pkg::GRANT_W-1:0]    granted_slot;
	logic [rspa_pkg::COUNT_W-1:0]    held_count;
	logic [rspa_pkg::COUNT_W-1:0]    free_count;

	// Local model of the pool and the register shadow.
	logic [SLOTS-1:0]             pool_busy = '0;
	logic [rspa_pkg::OWNER_W-1:0] pool_owner [SLOTS];
	rspa_pkg::cfg_t               pool_cfg = '0;

	pool_outcome_t pending_outcomes [$];
	int err_count = 0;
	int items_sent = 0;
	int outcomes_checked = 0;
	int settings_applied = 0;
	int outcome_tally [8];

	// Sender burst control.
	bit gaps_on = 1'b1;
	int burst_left = 0;

	// Receiver stall pattern and long hold-off.
	int         rcv_cycle = 0;
	logic [1:0] rcv_mode = RCV_ALWAYS;
	int         hold_token = 0;
	int         hold_seen = 0;
	int         hold_left = 0;

	reserved_slot_pool_admission #(
		.SLOTS(SLOTS),
		.LISTENERS(LISTENERS)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.cmd(cmd),
		.listener(listener),
		.slot_index(slot_index),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.status(status),
		.granted_slot(granted_slot),
		.held_count(held_count),
		.free_count(free_count)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("reserved_slot_pool_admission verification failed");
		$finish;
	end

	function automatic int held_by(int who);
		int n;
		n = 0;
		for (int i = 0; i < SLOTS; i++)
			if (pool_busy[i] && pool_owner[i] == who)
				n++;
		return n;
	endfunction

	function automatic int idle_slot_count();
		int n;
		n = 0;
		for (int i = 0; i < SLOTS; i++)
			if (!pool_busy[i])
				n++;
		return n;
	endfunction

	// Applies one request to the local pool and returns the result it should give.
	function automatic pool_outcome_t admit_and_update(pool_req_t q);
		pool_outcome_t r;
		int regs;
		int owed;
		int h;
		r.status = rspa_pkg::STATUS_IGNORED;
		r.granted = '0;
		regs = (pool_cfg.listener_count < LISTENERS) ? pool_cfg.listener_count : LISTENERS;
		case (q.op)
			rspa_pkg::CMD_ACCEPT: begin
				if (q.who >= regs || !pool_cfg.listener_enable[q.who]) begin
					r.status = rspa_pkg::STATUS_NOT_STARTED;
				end else begin
					owed = 0;
					for (int l = 0; l < regs; l++) begin
						if (l != q.who) begin
							h = held_by(l);
							if (h < pool_cfg.reserve[l])
								owed += pool_cfg.reserve[l] - h;
						end
					end
					if (held_by(q.who) >= pool_cfg.reserve[q.who] &&
						idle_slot_count() <= owed) begin
						r.status = rspa_pkg::STATUS_REFUSED;
					end else begin
						r.status = rspa_pkg::STATUS_NO_FREE;
						for (int i = 0; i < SLOTS; i++) begin
							if (!pool_busy[i]) begin
								pool_busy[i] = 1'b1;
								pool_owner[i] = q.who;
								r.granted = rspa_pkg::GRANT_W'(i);
								r.status = rspa_pkg::STATUS_ACCEPTED;
								break;
							end
						end
					end
				end
			end
			rspa_pkg::CMD_RELEASE: begin
				if (q.idx < SLOTS && pool_busy[q.idx]) begin
					pool_busy[q.idx] = 1'b0;
					r.status = rspa_pkg::STATUS_RELEASED;
				end
			end
			rspa_pkg::CMD_CLOSE: begin
				pool_busy = '0;
				r.status = rspa_pkg::STATUS_ALL_CLOSED;
			end
			default: begin
				r.status = rspa_pkg::STATUS_IGNORED;
			end
		endcase
		r.held = rspa_pkg::COUNT_W'(held_by(q.who));
		r.free = rspa_pkg::COUNT_W'(idle_slot_count());
		return r;
	endfunction

	// Predicts on accepted requests and checks accepted results.
	always @(posedge clk) begin
		pool_outcome_t exp;
		if (arst_n) begin
			if (rsp_valid && rsp_ready) begin
				if (pending_outcomes.size() == 0) begin
					$error("result with no request outstanding: status %0d", status);
					err_count++;
				end else begin
					exp = pending_outcomes.pop_front();
					outcomes_checked++;
					outcome_tally[exp.status]++;
					if (status !== exp.status) begin
						$error("status: expected %0d, got %0d", exp.status, status);
						err_count++;
					end
					if (granted_slot !== exp.granted) begin
						$error("granted_slot: expected %0d, got %0d", exp.granted, granted_slot);
						err_count++;
					end
					if (held_count !== exp.held) begin
						$error("held_count: expected %0d, got %0d", exp.held, held_count);
						err_count++;
					end
					if (free_count !== exp.free) begin
						$error("free_count: expected %0d, got %0d", exp.free, free_count);
						err_count++;
					end
				end
			end
			if (req_valid && req_ready)
				pending_outcomes.push_back(admit_and_update('{cmd, listener, slot_index}));
		end
	end

	// Receiver: a randomly chosen stall pattern, and a long hold-off on request.
	always @(posedge clk) begin
		rcv_cycle <= rcv_cycle + 1;
		if (rcv_cycle % 64 == 0)
			rcv_mode <= 2'($urandom_range(3, 0));
		if (hold_token != hold_seen) begin
			hold_seen <= hold_token;
			hold_left <= LONG_HOLD;
			rsp_ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			rsp_ready <= 1'b0;
		end else begin
			case (rcv_mode)
				RCV_ALWAYS:   rsp_ready <= 1'b1;
				RCV_COIN:     rsp_ready <= 1'($urandom_range(1, 0));
				RCV_SPARSE:   rsp_ready <= ($urandom_range(3, 0) == 0);
				RCV_PERIODIC: rsp_ready <= (rcv_cycle % 3 != 0);
				default:      rsp_ready <= 1'b1;
			endcase
		end
	end

	// Valid stays high between items of a burst; the caller lowers it when done.
	task automatic send_item(input logic [rspa_pkg::CMD_W-1:0] op,
			input logic [rspa_pkg::OWNER_W-1:0] who,
			input logic [rspa_pkg::IDX_W-1:0] idx);
		req_valid <= 1'b1;
		cmd <= op;
		listener <= who;
		slot_index <= idx;
		do @(posedge clk); while (!req_ready);
		items_sent++;
		if (gaps_on && burst_left == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(7, 1)) @(posedge clk);
			burst_left = ($urandom_range(7, 0) == 0) ?
				$urandom_range(60, 20) : $urandom_range(6, 0);
		end else if (burst_left != 0) begin
			burst_left--;
		end
	endtask

	task automatic wait_drained();
		req_valid <= 1'b0;
		while (pending_outcomes.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [rspa_pkg::REG_IDX_W-1:0] idx,
			input logic [rspa_pkg::APB_DATA_W-1:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			rspa_pkg::REG_RESERVE0: pool_cfg.reserve[0] = val[rspa_pkg::RES_W-1:0];
			rspa_pkg::REG_RESERVE1: pool_cfg.reserve[1] = val[rspa_pkg::RES_W-1:0];
			rspa_pkg::REG_RESERVE2: pool_cfg.reserve[2] = val[rspa_pkg::RES_W-1:0];
			rspa_pkg::REG_RESERVE3: pool_cfg.reserve[3] = val[rspa_pkg::RES_W-1:0];
			rspa_pkg::REG_LCOUNT:   pool_cfg.listener_count = val[rspa_pkg::LCNT_W-1:0];
			rspa_pkg::REG_ENABLE:   pool_cfg.listener_enable = val[rspa_pkg::ENA_W-1:0];
			default: ;
		endcase
	endtask

	function automatic rspa_pkg::cfg_t make_cfg(int r0, int r1, int r2, int r3, int lcount,
			int enables);
		rspa_pkg::cfg_t c;
		c.reserve[0] = rspa_pkg::RES_W'(r0);
		c.reserve[1] = rspa_pkg::RES_W'(r1);
		c.reserve[2] = rspa_pkg::RES_W'(r2);
		c.reserve[3] = rspa_pkg::RES_W'(r3);
		c.listener_count = rspa_pkg::LCNT_W'(lcount);
		c.listener_enable = rspa_pkg::ENA_W'(enables);
		return c;
	endfunction

	task automatic apply_settings(input rspa_pkg::cfg_t c);
		wait_drained();
		write_reg(rspa_pkg::REG_RESERVE0, rspa_pkg::APB_DATA_W'(c.reserve[0]));
		write_reg(rspa_pkg::REG_RESERVE1, rspa_pkg::APB_DATA_W'(c.reserve[1]));
		write_reg(rspa_pkg::REG_RESERVE2, rspa_pkg::APB_DATA_W'(c.reserve[2]));
		write_reg(rspa_pkg::REG_RESERVE3, rspa_pkg::APB_DATA_W'(c.reserve[3]));
		write_reg(rspa_pkg::REG_LCOUNT, rspa_pkg::APB_DATA_W'(c.listener_count));
		write_reg(rspa_pkg::REG_ENABLE, rspa_pkg::APB_DATA_W'(c.listener_enable));
		settings_applied++;
	endtask

	// Mostly accepts from live listeners and releases of held slots, so the pool
	// keeps running near full where the reservation rules matter.
	function automatic pool_req_t random_request();
		pool_req_t q;
		int pick;
		int regs;
		int held_slots [$];
		pick = $urandom_range(99, 0);
		q.who = rspa_pkg::OWNER_W'($urandom_range(3, 0));
		q.idx = rspa_pkg::IDX_W'($urandom_range(7, 0));
		regs = (pool_cfg.listener_count < LISTENERS) ? pool_cfg.listener_count : LISTENERS;
		if (pick < 55) begin
			q.op = rspa_pkg::CMD_ACCEPT;
			if (regs != 0 && $urandom_range(3, 0) != 0)
				q.who = rspa_pkg::OWNER_W'($urandom_range(regs - 1, 0));
		end else if (pick < 92) begin
			q.op = rspa_pkg::CMD_RELEASE;
			for (int i = 0; i < SLOTS; i++)
				if (pool_busy[i])
					held_slots.push_back(i);
			if (held_slots.size() != 0 && $urandom_range(3, 0) != 0)
				q.idx = rspa_pkg::IDX_W'(held_slots[$urandom_range(held_slots.size() - 1, 0)]);
		end else if (pick < 96) begin
			q.op = rspa_pkg::CMD_CLOSE;
		end else begin
			q.op = CMD_UNUSED;
		end
		return q;
	endfunction

	task automatic send_random(input int n);
		pool_req_t q;
		for (int k = 0; k < n; k++) begin
			q = random_request();
			send_item(q.op, q.who, q.idx);
		end
	endtask

	// Reset state: nobody is registered.
	task automatic test_unconfigured();
		send_item(rspa_pkg::CMD_ACCEPT, 2'd0, 3'd0);
		send_item(CMD_UNUSED, 2'd3, 3'd7);
		send_item(rspa_pkg::CMD_RELEASE, 2'd1, 3'd7);
		send_item(rspa_pkg::CMD_CLOSE, 2'd2, 3'd5);
	endtask

	// Listener 3 is registered but disabled, yet its reserve still counts.
	task automatic test_reservations();
		apply_settings(make_cfg(2, 3, 0, 1, 4, 4'b0111));
		send_item(rspa_pkg::CMD_ACCEPT, 2'd3, 3'd0);
		repeat (3) send_item(rspa_pkg::CMD_ACCEPT, 2'd2, 3'd1);
		repeat (3) send_item(rspa_pkg::CMD_ACCEPT, 2'd0, 3'd2);
		send_item(rspa_pkg::CMD_RELEASE, 2'd1, 3'd2);
		send_item(rspa_pkg::CMD_RELEASE, 2'd1, 3'd2);
	endtask

	// Take six of the eight slots, then ask from below and from at-or-above reserve.
	// The listener count is above the number of listeners and gets clamped.
	task automatic test_full_pool();
		apply_settings(make_cfg(8, 5, 0, 0, 7, 4'b1111));
		repeat (5) send_item(rspa_pkg::CMD_ACCEPT, 2'd1, 3'd4);
		send_item(rspa_pkg::CMD_ACCEPT, 2'd0, 3'd6);
		send_item(rspa_pkg::CMD_ACCEPT, 2'd1, 3'd3);
		send_item(rspa_pkg::CMD_ACCEPT, 2'd3, 3'd0);
		send_item(rspa_pkg::CMD_CLOSE, 2'd1, 3'd0);
	endtask

	task automatic test_unregistered();
		apply_settings(make_cfg(0, 0, 0, 0, 2, 4'b1111));
		send_item(rspa_pkg::CMD_ACCEPT, 2'd3, 3'd7);
		send_item(rspa_pkg::CMD_ACCEPT, 2'd1, 3'd2);
	endtask

	task automatic test_random_settings();
		apply_settings(make_cfg(0, 0, 0, 0, 4, 4'b1111));
		send_random(ITEMS_PER_SETTING);
		apply_settings(make_cfg(8, 8, 8, 8, 4, 4'b1111));
		send_random(ITEMS_PER_SETTING);
		apply_settings(make_cfg(1, 2, 3, 2, 3, 4'b1011));
		send_random(ITEMS_PER_SETTING);
		apply_settings(make_cfg(0, 8, 0, 8, 1, 4'b0001));
		send_random(ITEMS_PER_SETTING / 2);
		apply_settings(make_cfg(3, 3, 3, 3, 0, 4'b0000));
		send_random(40);
		repeat (2) begin
			apply_settings(make_cfg($urandom_range(8, 0), $urandom_range(8, 0),
				$urandom_range(8, 0), $urandom_range(8, 0),
				$urandom_range(7, 0), $urandom_range(15, 0)));
			send_random(ITEMS_PER_SETTING);
		end
	endtask

	// The receiver holds off while the sender keeps going without gaps.
	task automatic test_output_backpressure();
		apply_settings(make_cfg(2, 1, 2, 1, 4, 4'b1111));
		gaps_on = 1'b0;
		hold_token <= hold_token + 1;
		send_random(30);
		gaps_on = 1'b1;
	endtask

	task automatic test_sender_pause();
		send_random(15);
		wait_drained();
		send_random(15);
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_unconfigured();
		test_reservations();
		test_full_pool();
		test_unregistered();
		test_random_settings();
		test_output_backpressure();
		test_sender_pause();
		wait_drained();
		repeat (10) @(posedge clk);
		$display("Sent %0d requests under %0d register settings, checked %0d results.",
			items_sent, settings_applied, outcomes_checked);
		$display({"Outcomes: %0d accepted, %0d not started, %0d refused, %0d pool full, ",
			"%0d released, %0d ignored, %0d closed."},
			outcome_tally[rspa_pkg::STATUS_ACCEPTED],
			outcome_tally[rspa_pkg::STATUS_NOT_STARTED],
			outcome_tally[rspa_pkg::STATUS_REFUSED],
			outcome_tally[rspa_pkg::STATUS_NO_FREE],
			outcome_tally[rspa_pkg::STATUS_RELEASED],
			outcome_tally[rspa_pkg::STATUS_IGNORED],
			outcome_tally[rspa_pkg::STATUS_ALL_CLOSED]);
		if (err_count == 0 && pending_outcomes.size() == 0) begin
			$display("reserved_slot_pool_admission verification clean");
		end else begin
			$display("reserved_slot_pool_admission verification failed");
		end
		$finish;
	end

endmodule

[reserved_slot_pool_admission.f]
hdl/rspa_pkg.sv
hdl/rspa_ram.sv
hdl/rspa_cfg.sv
hdl/rspa_ctrl.sv
hdl/reserved_slot_pool_admission.sv
tb/sv/tb_reserved_slot_pool_admission.sv
